@@ hw/rtl/spe_pkg.sv @@
// Shared constants and types for the sparse polynomial evaluator.
package spe_pkg;

  localparam int MAX_TERMS = 64;
  localparam int EXP_BITS  = 16;

  // Stored exponent width: only the low EXP_BITS bits of the 16-bit field are kept
  localparam int EXP_W = (EXP_BITS < 16) ? EXP_BITS : 16;
  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_TERMS);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t            coef;
    logic [EXP_W-1:0] expo;
  } term_t;

endpackage

@@ hw/rtl/spe_if.sv @@
// Command and result channel interfaces for the sparse polynomial evaluator.
interface spe_cmd_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic               first_term;
  logic signed [31:0] term_coefficient;
  logic        [15:0] term_exponent;
  logic signed [31:0] x_value;

  modport source (
    output valid, mode, first_term, term_coefficient, term_exponent, x_value,
    input  ready
  );
  modport sink (
    input  valid, mode, first_term, term_coefficient, term_exponent, x_value,
    output ready
  );
endinterface

interface spe_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] poly_value;
  logic               terms_dropped;

  modport source (
    output valid, poly_value, terms_dropped,
    input  ready
  );
  modport sink (
    input  valid, poly_value, terms_dropped,
    output ready
  );
endinterface

@@ hw/rtl/spe_term_mem.sv @@
// Term table: one write port, one registered read port.
module spe_term_mem
  import spe_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  term_t            wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output term_t            rd_data
);

  term_t mem [MAX_TERMS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/sparse_polynomial_evaluator.sv @@
// Top level of the sparse polynomial evaluator: sequencer, shared multiplier, result register.
//
// Load beats (mode 0) append one (coefficient, exponent) term to a 64-entry table;
// first_term restarts the table and clears the drop flag, and a load into a full table
// is discarded and sets terms_dropped until the next first_term. An evaluate beat
// (mode 1) returns sum(coef * x^exp) modulo 2^32. Cmd ready is low for the whole
// evaluation. One 32x32 multiplier, low half only, is shared by the power and coefficient
// multiply steps. Per stored term the sequencer fetches the term (read, then setup), then
// for each set exponent bit multiplies into the power and for each bit position below the
// highest set bit squares, sees the exponent run out, and finishes with the coefficient
// multiply and the sum. With an empty table it goes straight to its finishing state; the
// result shows up in the cycle after the finishing cycle. A stalled result holds the
// sequencer in its finishing state only while an older result is still waiting.
// The result waits in an output register and the next command beat may be taken meanwhile.
module sparse_polynomial_evaluator
  import spe_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  spe_cmd_if.sink  cmd,
  spe_res_if.source res
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_SETUP = 7'b0000100,
    S_POW   = 7'b0001000,
    S_COEF  = 7'b0010000,
    S_SUM   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] term_count;
  logic             overflow_seen;
  logic [IDX_W-1:0] idx;
  word_t            x_hold;
  word_t            coef;
  logic [EXP_W-1:0] e;
  word_t            acc;
  word_t            sq;
  word_t            sum;
  logic             out_valid;
  word_t            out_value;
  logic             out_dropped;

  logic             cmd_take;
  logic             load_take;
  logic             table_full;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  term_t            wr_data;
  term_t            rd_data;
  logic             last_term;
  logic             out_free;

  word_t            mul_a;
  word_t            mul_b;
  word_t            mul_p;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_take  = cmd.valid && cmd.ready;
  assign load_take = cmd_take && (cmd.mode == MODE_LOAD);

  assign table_full = (term_count >= MAX_COUNT);

  // Store the term unless the table is full; first_term always stores at the bottom
  assign wr_en        = load_take && (cmd.first_term || !table_full);
  assign wr_addr      = cmd.first_term ? '0 : term_count[IDX_W-1:0];
  assign wr_data.coef = word_t'(cmd.term_coefficient);
  assign wr_data.expo = cmd.term_exponent[EXP_W-1:0];

  spe_term_mem u_term_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  assign last_term = (CNT_W'(idx) + CNT_W'(1)) == term_count;
  assign out_free  = !out_valid || res.ready;

  // Shared multiplier: pick operands by step, keep the low 32 bits
  always_comb begin
    mul_a = sq;
    mul_b = sq;
    if (state == S_COEF) begin
      mul_a = coef;
      mul_b = acc;
    end else if (e[0]) begin
      mul_a = acc;
      mul_b = sq;
    end
  end

  assign mul_p = 32'(mul_a * mul_b);

  // Table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      term_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (load_take) begin
      if (cmd.first_term) begin
        term_count    <= CNT_W'(1);
        overflow_seen <= 1'b0;
      end else if (table_full) begin
        overflow_seen <= 1'b1;
      end else begin
        term_count <= term_count + CNT_W'(1);
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_take && cmd.mode == MODE_EVAL) begin
            state <= (term_count == '0) ? S_DONE : S_READ;
          end
        end
        S_READ:  state <= S_SETUP;
        S_SETUP: state <= S_POW;
        S_POW: begin
          if (e == '0) begin
            state <= S_COEF;
          end
        end
        S_COEF: state <= S_SUM;
        S_SUM:  state <= last_term ? S_DONE : S_READ;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        x_hold <= word_t'(cmd.x_value);
        idx    <= '0;
        sum    <= '0;
      end
      S_SETUP: begin
        coef <= rd_data.coef;
        e    <= rd_data.expo;
        acc  <= 32'd1;
        sq   <= x_hold;
      end
      S_POW: begin
        // Fold in the current power for a set bit, else square and advance
        if (e[0]) begin
          acc <= mul_p;
          e   <= e & ~EXP_W'(1);
        end else if (e != '0) begin
          sq <= mul_p;
          e  <= e >> 1;
        end
      end
      S_COEF: acc <= mul_p;
      S_SUM: begin
        sum <= sum + acc;
        idx <= idx + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_value   <= sum;
      out_dropped <= overflow_seen;
    end
  end

  assign res.valid         = out_valid;
  assign res.poly_value    = $signed(out_value);
  assign res.terms_dropped = out_dropped;

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state is not one-hot");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    term_count <= MAX_COUNT)
    else $error("term count above table size");

  a_eval_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && cmd.mode == MODE_EVAL) |=> state != S_IDLE)
    else $error("evaluate beat did not start the sequencer");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result appeared without a finished evaluation");

endmodule
